@@ rtl/mrts_pkg.sv @@
// Shared types, constants and helpers for the multi-register transfer sequencer.
// Used by the front, queue, back and top-level modules; no dependencies.
package mrts_pkg;

    localparam int ADDR_W     = 32;
    localparam int MASK_W     = 16;
    localparam int REG_W      = 4;
    localparam int CYC_W      = 8;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 80;
    localparam int M_USER_W   = 3;

    localparam logic [2:0] AM_POSTINC  = 3'd3;
    localparam logic [2:0] AM_PREDEC   = 3'd4;
    localparam logic [2:0] AM_DISP     = 3'd5;
    localparam logic [2:0] AM_INDEX    = 3'd6;
    localparam logic [2:0] AM_EXT      = 3'd7;
    localparam logic [2:0] EXT_ABS_W   = 3'd0;
    localparam logic [2:0] EXT_ABS_L   = 3'd1;
    localparam logic [2:0] EXT_PC_DISP = 3'd2;
    localparam logic [2:0] EXT_PC_IDX  = 3'd3;

    localparam logic [CYC_W-1:0] CYC_BASE_STORE = 8'd8;
    localparam logic [CYC_W-1:0] CYC_BASE_LOAD  = 8'd12;
    localparam logic [CYC_W-1:0] CYC_PER_WORD   = 8'd4;
    localparam logic [CYC_W-1:0] CYC_PER_LONG   = 8'd8;
    localparam logic [CYC_W-1:0] CYC_OVH_4      = 8'd4;
    localparam logic [CYC_W-1:0] CYC_OVH_6      = 8'd6;
    localparam logic [CYC_W-1:0] CYC_OVH_8      = 8'd8;
    localparam logic [CYC_W-1:0] CYC_OVH_NONE   = 8'd0;

    localparam logic [ADDR_W-1:0] STEP_WORD = ADDR_W'(2);
    localparam logic [ADDR_W-1:0] STEP_LONG = ADDR_W'(4);
    localparam logic [ADDR_W-1:0] HALF_OFS  = ADDR_W'(2);
    localparam logic [REG_W-1:0]  REG_TOP   = 4'd15;

    typedef enum logic [2:0] {
        KIND_WR_WORD = 3'd0,
        KIND_WR_LONG = 3'd1,
        KIND_WR_LOW  = 3'd2,
        KIND_WR_HIGH = 3'd3,
        KIND_RD_WORD = 3'd4,
        KIND_RD_LONG = 3'd5,
        KIND_DUMMY   = 3'd6,
        KIND_NONE    = 3'd7
    } kind_t;

    // One classified instruction as it travels from front to back.
    typedef struct packed {
        logic                load;
        logic                is_long;
        logic                predec;
        logic                wb_en;
        logic [MASK_W-1:0]   mask;
        logic [ADDR_W-1:0]   addr;
        logic [CYC_W-1:0]    cyc_init;
    } desc_t;

    // Queue status seen by the front and back.
    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

    function automatic logic [CYC_W-1:0] ea_overhead(input logic [2:0] am,
                                                    input logic [2:0] ar);
        logic [CYC_W-1:0] ovh;
        ovh = CYC_OVH_NONE;
        if (am == AM_DISP) begin
            ovh = CYC_OVH_4;
        end else if (am == AM_INDEX) begin
            ovh = CYC_OVH_6;
        end else if (am == AM_EXT) begin
            if (ar == EXT_ABS_W || ar == EXT_PC_DISP) begin
                ovh = CYC_OVH_4;
            end else if (ar == EXT_ABS_L) begin
                ovh = CYC_OVH_8;
            end else if (ar == EXT_PC_IDX) begin
                ovh = CYC_OVH_6;
            end
        end
        return ovh;
    endfunction

endpackage

@@ rtl/mrts_front.sv @@
// Front end: accepts instruction words and classifies them into descriptors.
// Depends on mrts_pkg; pushes into mrts_queue.
module mrts_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // mode, long_size, addressing_mode[2:0], addressing_register[2:0],
    // register_mask[15:0], start_address[31:0]
    input  logic [mrts_pkg::S_DATA_W-1:0]  s_tdata,
    input  mrts_pkg::q_stat_t              q_stat,
    output logic                           push,
    output mrts_pkg::desc_t                push_desc
);

    logic       load;
    logic       is_long;
    logic [2:0] am;
    logic [2:0] ar;

    assign load    = s_tdata[0];
    assign is_long = s_tdata[1];
    assign am      = s_tdata[4:2];
    assign ar      = s_tdata[7:5];

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && !q_stat.full;

    always_comb begin
        push_desc.load     = load;
        push_desc.is_long  = is_long;
        push_desc.predec   = !load && (am == mrts_pkg::AM_PREDEC);
        push_desc.wb_en    = (!load && (am == mrts_pkg::AM_PREDEC)) ||
                             (load && (am == mrts_pkg::AM_POSTINC));
        push_desc.mask     = s_tdata[23:8];
        push_desc.addr     = s_tdata[24 +: mrts_pkg::ADDR_W];
        push_desc.cyc_init = (load ? mrts_pkg::CYC_BASE_LOAD : mrts_pkg::CYC_BASE_STORE)
                             + mrts_pkg::ea_overhead(am, ar);
    end

endmodule

@@ rtl/mrts_queue.sv @@
// Short descriptor queue between front and back.
// Depends on mrts_pkg.
module mrts_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mrts_pkg::desc_t   push_desc,
    input  logic              pop,
    output mrts_pkg::desc_t   pop_desc,
    output mrts_pkg::q_stat_t q_stat
);

    mrts_pkg::desc_t                    entry_reg [mrts_pkg::Q_DEPTH];
    logic [mrts_pkg::Q_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [mrts_pkg::Q_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [mrts_pkg::Q_CNT_W-1:0]       count_reg, count_next;

    assign q_stat.full  = (count_reg == mrts_pkg::Q_CNT_W'(mrts_pkg::Q_DEPTH));
    assign q_stat.valid = (count_reg != '0);
    assign pop_desc     = entry_reg[rd_ptr_reg];

    function automatic logic [mrts_pkg::Q_PTR_W-1:0] ptr_inc(
        input logic [mrts_pkg::Q_PTR_W-1:0] p);
        logic [mrts_pkg::Q_PTR_W-1:0] r;
        if (p == mrts_pkg::Q_PTR_W'(mrts_pkg::Q_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + mrts_pkg::Q_CNT_W'(push) - mrts_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

@@ rtl/mrts_back.sv @@
// Back end: walks one descriptor's register mask and issues one bus access per cycle
// into an output register whenever it is free. Depends on mrts_pkg; pulls from mrts_queue.
module mrts_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mrts_pkg::q_stat_t               q_stat,
    input  mrts_pkg::desc_t                 pop_desc,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mrts_pkg::M_DATA_W-1:0]   m_tdata,
    output logic [mrts_pkg::M_USER_W-1:0]   m_tuser,
    output logic                            m_tlast
);

    logic                                busy_reg, busy_next;
    mrts_pkg::desc_t                     cur_reg, cur_next;
    logic [mrts_pkg::MASK_W-1:0]         rem_reg, rem_next;
    logic [mrts_pkg::ADDR_W-1:0]         addr_reg, addr_next;
    logic [mrts_pkg::CYC_W-1:0]          cyc_reg, cyc_next;
    logic                                half_reg, half_next;
    logic [mrts_pkg::REG_W-1:0]          hreg_reg, hreg_next;

    logic                                m_valid_reg, m_valid_next;
    logic [mrts_pkg::M_DATA_W-1:0]       m_data_reg, m_data_next;
    mrts_pkg::kind_t                     m_kind_reg, m_kind_next;
    logic                                m_last_reg, m_last_next;

    logic                                out_free;
    logic                                emit;
    logic [mrts_pkg::REG_W-1:0]          low_idx;
    logic [mrts_pkg::MASK_W-1:0]         rem_clr;
    logic [mrts_pkg::ADDR_W-1:0]         step;
    logic [mrts_pkg::ADDR_W-1:0]         dec_addr;
    logic [mrts_pkg::CYC_W-1:0]          per_reg;
    logic [mrts_pkg::ADDR_W-1:0]         e_addr;
    logic [mrts_pkg::REG_W-1:0]          e_reg;
    mrts_pkg::kind_t                     e_kind;
    logic                                e_last;
    logic                                e_wb;

    assign out_free = !m_valid_reg || m_tready;
    assign emit     = busy_reg && out_free;
    assign step     = cur_reg.is_long ? mrts_pkg::STEP_LONG : mrts_pkg::STEP_WORD;
    assign per_reg  = cur_reg.is_long ? mrts_pkg::CYC_PER_LONG : mrts_pkg::CYC_PER_WORD;
    assign dec_addr = addr_reg - step;
    assign rem_clr  = rem_reg & (rem_reg - 1'b1);

    // Lowest set bit of the remaining mask.
    always_comb begin
        low_idx = '0;
        for (int i = mrts_pkg::MASK_W - 1; i >= 0; i--) begin
            if (rem_reg[i]) begin
                low_idx = mrts_pkg::REG_W'(i);
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        cur_next  = cur_reg;
        rem_next  = rem_reg;
        addr_next = addr_reg;
        cyc_next  = cyc_reg;
        half_next = half_reg;
        hreg_next = hreg_reg;
        pop       = 1'b0;
        e_addr    = '0;
        e_reg     = '0;
        e_kind    = mrts_pkg::KIND_NONE;
        e_last    = 1'b0;

        if (!busy_reg) begin
            if (q_stat.valid) begin
                pop       = 1'b1;
                busy_next = 1'b1;
                cur_next  = pop_desc;
                rem_next  = pop_desc.mask;
                addr_next = pop_desc.addr;
                cyc_next  = pop_desc.cyc_init;
                half_next = 1'b0;
            end
        end else if (out_free) begin
            priority if (cur_reg.predec && half_reg) begin
                // second half of a predecrement long
                e_addr    = addr_reg;
                e_reg     = hreg_reg;
                e_kind    = mrts_pkg::KIND_WR_HIGH;
                e_last    = (rem_reg == '0);
                half_next = 1'b0;
            end else if (cur_reg.predec && rem_reg != '0) begin
                rem_next  = rem_clr;
                addr_next = dec_addr;
                cyc_next  = cyc_reg + per_reg;
                if (cur_reg.is_long) begin
                    e_addr    = dec_addr + mrts_pkg::HALF_OFS;
                    e_reg     = mrts_pkg::REG_TOP - low_idx;
                    e_kind    = mrts_pkg::KIND_WR_LOW;
                    half_next = 1'b1;
                    hreg_next = mrts_pkg::REG_TOP - low_idx;
                end else begin
                    e_addr = dec_addr;
                    e_reg  = mrts_pkg::REG_TOP - low_idx;
                    e_kind = mrts_pkg::KIND_WR_WORD;
                    e_last = (rem_clr == '0);
                end
            end else if (rem_reg != '0) begin
                rem_next  = rem_clr;
                addr_next = addr_reg + step;
                cyc_next  = cyc_reg + per_reg;
                e_addr    = addr_reg;
                e_reg     = low_idx;
                if (cur_reg.load) begin
                    e_kind = cur_reg.is_long ? mrts_pkg::KIND_RD_LONG : mrts_pkg::KIND_RD_WORD;
                end else begin
                    e_kind = cur_reg.is_long ? mrts_pkg::KIND_WR_LONG : mrts_pkg::KIND_WR_WORD;
                    e_last = (rem_clr == '0);
                end
            end else if (cur_reg.load) begin
                e_addr = addr_reg;
                e_kind = mrts_pkg::KIND_DUMMY;
                e_last = 1'b1;
            end else begin
                // empty store list: report only the closing fields
                e_kind = mrts_pkg::KIND_NONE;
                e_last = 1'b1;
            end
            if (e_last) begin
                busy_next = 1'b0;
            end
        end
    end

    assign e_wb = e_last && cur_reg.wb_en;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_kind_next  = m_kind_reg;
        m_last_next  = m_last_reg;
        if (out_free) begin
            m_valid_next = emit;
        end
        if (emit) begin
            m_data_next = {3'b000,
                           e_last ? cyc_next : mrts_pkg::CYC_W'(0),
                           e_wb ? 32'(addr_next) : 32'd0,
                           e_wb,
                           e_reg,
                           32'(e_addr)};
            m_kind_next = e_kind;
            m_last_next = e_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            half_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            half_reg    <= half_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        rem_reg    <= rem_next;
        addr_reg   <= addr_next;
        cyc_reg    <= cyc_next;
        hreg_reg   <= hreg_next;
        m_data_reg <= m_data_next;
        m_kind_reg <= m_kind_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_half_only_predec_long: assert property (@(posedge aclk) disable iff (!aresetn)
        half_reg |-> (busy_reg && cur_reg.predec && cur_reg.is_long))
        else $error("half-word pending outside a predecrement long store");

    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && e_last) |=> !busy_reg)
        else $error("sequencer still busy after final word");

    a_pop_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (!busy_reg && q_stat.valid))
        else $error("descriptor taken while busy or queue empty");

    a_wb_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[36]) |-> m_tlast)
        else $error("writeback flagged on a word that is not last");
`endif

endmodule

@@ rtl/multi_register_transfer_sequencer_top.sv @@
// An instruction word passes through the queue entry, the back end's descriptor registers and the output register.
// An instruction yields n result words, n = its result count (1 to 32); the back end walks
// one access per cycle unless the output stalls, and takes no new descriptor until the last word.
// A two-entry descriptor queue lets the input side take words while the walk runs.
// Reset (aresetn low, synchronous) empties the queue, idles the walk, drops m_tvalid.
// Depends on mrts_pkg, mrts_front, mrts_queue, mrts_back.
module multi_register_transfer_sequencer_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // mode, long_size, addressing_mode[2:0], addressing_register[2:0],
    // register_mask[15:0], start_address[31:0]
    input  logic [mrts_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // bus_address[31:0], register_index[3:0], writeback_valid,
    // writeback_address[31:0], cycle_count[7:0], zero pad
    output logic [mrts_pkg::M_DATA_W-1:0]  m_tdata,
    // access_kind[2:0]
    output logic [mrts_pkg::M_USER_W-1:0]  m_tuser,
    output logic                           m_tlast
);

    mrts_pkg::q_stat_t q_stat;
    mrts_pkg::desc_t   push_desc;
    mrts_pkg::desc_t   pop_desc;
    logic              push;
    logic              pop;

    mrts_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_desc (push_desc)
    );

    mrts_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .q_stat    (q_stat)
    );

    mrts_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .pop_desc (pop_desc),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
